/* rtl/core/cbp_pkg.sv */
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types and constants for the channel block pack with zero padding.
// ----------------------------------------------------------------------------
package cbp_pkg;

    // Fixed field widths of the ports and configuration registers.
    localparam int VALUE_W    = 32;
    localparam int DST_W      = 27;
    localparam int AREA_W     = 13;
    localparam int DEPTH_W    = 11;
    localparam int STRIDE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Comparison width that holds any effective area or depth (up to 65536).
    localparam int CMP_W = 17;

    // Widths that cover the largest supported position and lane values.
    localparam int POS_MAX_W  = 16;
    localparam int LANE_MAX_W = 5;

    // Output queue in the burst unit.
    localparam int OUT_SLOTS = 3;
    localparam int SLOT_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_AREA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd2;

    // Source of one lane of a burst.
    typedef enum logic [1:0] {
        LANE_STORED,
        LANE_OWN,
        LANE_PAD
    } lane_kind_t;

    // One final-row element handed to the burst unit.
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [LANE_MAX_W-1:0] lane;
        logic [POS_MAX_W-1:0]  pos;
        logic [DST_W-1:0]      base;
        logic                  done;
    } job_req_t;

    // Burst unit status seen by the input sequencer.
    typedef struct packed {
        logic                  job_free;
        logic                  busy;
        logic [POS_MAX_W-1:0]  pos;
        logic [LANE_MAX_W-1:0] rd_lane;
    } burst_stat_t;

endpackage

/* rtl/core/channel_block_pack_zero_pad.sv */
// ----------------------------------------------------------------------------
// channel_block_pack_zero_pad
// Repacks a planar tensor into interleaved blocks of PACK_LANES channels.
// ----------------------------------------------------------------------------
// A final-row element passes the job registers, the s1 stage and the output
// queue. Stored-row elements are taken one per cycle unless a pending burst
// read shares their entry; a final-row element gives PACK_LANES results, one
// per cycle while the queue has room; the next enters as its last lane issues.
// Reset: configuration registers return to 1 and the counters to zero; the
// line store is not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
module channel_block_pack_zero_pad
    import cbp_pkg::*;
#(
    parameter int MAX_AREA   = 4096,
    parameter int MAX_DEPTH  = 1024,
    parameter int PACK_LANES = 8,
    parameter int ELEM_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_W-1:0]    value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_W-1:0]    out_value,
    output logic [DST_W-1:0]      dst_index,
    output logic                  last,
    output logic                  tensor_done
);

    // The line store keeps every channel row of a block except the last one,
    // one region of MAX_AREA entries per lane.
    localparam int STORE_N = (PACK_LANES - 1) * MAX_AREA;
    localparam int ADDR_W  = (STORE_N > 1) ? $clog2(STORE_N) : 1;

    burst_stat_t          stat;
    job_req_t             job;
    logic                 job_load;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ELEM_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ELEM_BITS-1:0] rd_data;

    // The sequencer walks the planar order. Elements of stored rows are
    // written straight into the line store on transfer; an element of the
    // block's last row is handed to the burst unit together with its
    // destination base index.
    cbp_seq #(
        .MAX_AREA   (MAX_AREA),
        .MAX_DEPTH  (MAX_DEPTH),
        .PACK_LANES (PACK_LANES),
        .ELEM_BITS  (ELEM_BITS),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .stat      (stat),
        .job_load  (job_load),
        .job       (job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    cbp_store #(
        .DEPTH_N (STORE_N),
        .ADDR_W  (ADDR_W),
        .DATA_W  (ELEM_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The burst unit reads the stored lanes one per cycle while its output
    // queue has room, inserts the element itself and the zero padding, and
    // queues the results; a stalled output that fills the queue holds issue.
    cbp_burst #(
        .MAX_AREA   (MAX_AREA),
        .PACK_LANES (PACK_LANES),
        .ELEM_BITS  (ELEM_BITS),
        .ADDR_W     (ADDR_W)
    ) u_burst (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job         (job),
        .stat        (stat),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .dst_index   (dst_index),
        .last        (last),
        .tensor_done (tensor_done)
    );

endmodule

/* rtl/core/cbp_store.sv */
// ----------------------------------------------------------------------------
// cbp_store
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbp_store #(
    parameter int DEPTH_N = 28672,
    parameter int ADDR_W  = 15,
    parameter int DATA_W  = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH_N];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/cbp_seq.sv */
// ----------------------------------------------------------------------------
// cbp_seq
// Configuration registers, planar position counters and input handshake.
// ----------------------------------------------------------------------------
module cbp_seq
    import cbp_pkg::*;
#(
    parameter int MAX_AREA   = 4096,
    parameter int MAX_DEPTH  = 1024,
    parameter int PACK_LANES = 8,
    parameter int ELEM_BITS  = 32,
    parameter int ADDR_W     = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_W-1:0]    value,
    input  burst_stat_t           stat,
    output logic                  job_load,
    output job_req_t              job,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [ELEM_BITS-1:0]  wr_data
);

    localparam int POS_W  = $clog2(MAX_AREA);
    localparam int LANE_W = $clog2(PACK_LANES);
    localparam int CH_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [AREA_W-1:0]   area_reg,   area_next;
    logic [DEPTH_W-1:0]  depth_reg,  depth_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [LANE_W-1:0]   lane_reg,   lane_next;
    logic [CH_W-1:0]     chan_reg,   chan_next;
    logic [DST_W-1:0]    block_base_reg, block_base_next;

    logic [CMP_W-1:0] eff_area;
    logic [CMP_W-1:0] eff_depth;
    logic             pos_end;
    logic             final_chan;
    logic             lane_top;
    logic             final_row;
    logic             conflict;
    logic             accept;

    // Out-of-range sizes are clamped into the supported range.
    always_comb
    begin
        if (area_reg == '0)
            eff_area = CMP_W'(1);
        else if (CMP_W'(area_reg) > CMP_W'(MAX_AREA))
            eff_area = CMP_W'(MAX_AREA);
        else
            eff_area = CMP_W'(area_reg);

        if (depth_reg == '0)
            eff_depth = CMP_W'(1);
        else if (CMP_W'(depth_reg) > CMP_W'(MAX_DEPTH))
            eff_depth = CMP_W'(MAX_DEPTH);
        else
            eff_depth = CMP_W'(depth_reg);
    end

    assign pos_end    = (CMP_W'(pos_reg) + CMP_W'(1)) == eff_area;
    assign final_chan = (CMP_W'(chan_reg) + CMP_W'(1)) == eff_depth;
    assign lane_top   = lane_reg == LANE_W'(PACK_LANES - 1);
    assign final_row  = final_chan || lane_top;

    // A store write must not overtake a read the burst unit has yet to issue
    // at the same entry.
    assign conflict = stat.busy && (POS_MAX_W'(pos_reg) == stat.pos)
                      && (LANE_MAX_W'(lane_reg) >= stat.rd_lane);

    assign in_ready  = final_row ? stat.job_free : !conflict;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign wr_en   = accept && !final_row;
    assign wr_addr = ADDR_W'(lane_reg * MAX_AREA) + ADDR_W'(pos_reg);
    assign wr_data = value[ELEM_BITS-1:0];

    assign job_load   = accept && final_row;
    assign job.value  = VALUE_W'(value[ELEM_BITS-1:0]);
    assign job.lane   = LANE_MAX_W'(lane_reg);
    assign job.pos    = POS_MAX_W'(pos_reg);
    assign job.base   = block_base_reg + DST_W'(pos_reg * PACK_LANES);
    assign job.done   = final_chan && pos_end;

    always_comb
    begin
        area_next       = area_reg;
        depth_next      = depth_reg;
        stride_next     = stride_reg;
        pos_next        = pos_reg;
        lane_next       = lane_reg;
        chan_next       = chan_reg;
        block_base_next = block_base_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AREA:   area_next   = cfg_data[AREA_W-1:0];
                CFG_DEPTH:  depth_next  = cfg_data[DEPTH_W-1:0];
                CFG_STRIDE: stride_next = cfg_data[STRIDE_W-1:0];
                default:    ;
            endcase
            // Any write restarts the tensor.
            pos_next        = '0;
            lane_next       = '0;
            chan_next       = '0;
            block_base_next = '0;
        end
        else if (accept)
        begin
            if (pos_end)
            begin
                pos_next = '0;
                if (final_chan)
                begin
                    chan_next       = '0;
                    lane_next       = '0;
                    block_base_next = '0;
                end
                else
                begin
                    chan_next = chan_reg + CH_W'(1);
                    if (lane_top)
                    begin
                        lane_next       = '0;
                        block_base_next = block_base_reg
                                          + DST_W'(stride_reg * PACK_LANES);
                    end
                    else
                    begin
                        lane_next = lane_reg + LANE_W'(1);
                    end
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg       <= AREA_W'(1);
            depth_reg      <= DEPTH_W'(1);
            stride_reg     <= STRIDE_W'(1);
            pos_reg        <= '0;
            lane_reg       <= '0;
            chan_reg       <= '0;
            block_base_reg <= '0;
        end
        else
        begin
            area_reg       <= area_next;
            depth_reg      <= depth_next;
            stride_reg     <= stride_next;
            pos_reg        <= pos_next;
            lane_reg       <= lane_next;
            chan_reg       <= chan_next;
            block_base_reg <= block_base_next;
        end
    end

endmodule

/* rtl/core/cbp_burst.sv */
// ----------------------------------------------------------------------------
// cbp_burst
// Expands one final-row element into a burst of lanes, reading stored lanes
// from the line store, and queues the results for the output channel.
// ----------------------------------------------------------------------------
module cbp_burst
    import cbp_pkg::*;
#(
    parameter int MAX_AREA   = 4096,
    parameter int PACK_LANES = 8,
    parameter int ELEM_BITS  = 32,
    parameter int ADDR_W     = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_load,
    input  job_req_t             job,
    output burst_stat_t          stat,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [ELEM_BITS-1:0] rd_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VALUE_W-1:0]   out_value,
    output logic [DST_W-1:0]     dst_index,
    output logic                 last,
    output logic                 tensor_done
);

    localparam int POS_W  = $clog2(MAX_AREA);
    localparam int LANE_W = $clog2(PACK_LANES);

    // Current job.
    logic                 job_v_reg,     job_v_next;
    logic [ELEM_BITS-1:0] job_value_reg;
    logic [LANE_W-1:0]    job_lane_reg;
    logic [POS_W-1:0]     job_pos_reg;
    logic [DST_W-1:0]     job_base_reg;
    logic                 job_done_reg;
    logic [LANE_W-1:0]    rd_lane_reg,   rd_lane_next;

    // Stage aligned with the store read data.
    logic                 s1_v_reg;
    lane_kind_t           s1_kind_reg;
    logic [ELEM_BITS-1:0] s1_value_reg;
    logic [DST_W-1:0]     s1_dst_reg;
    logic                 s1_last_reg;
    logic                 s1_done_reg;

    // Output queue.
    logic [ELEM_BITS-1:0] q_value [OUT_SLOTS];
    logic [DST_W-1:0]     q_dst   [OUT_SLOTS];
    logic                 q_last  [OUT_SLOTS];
    logic                 q_done  [OUT_SLOTS];
    logic [SLOT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [SLOT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [SLOT_W-1:0]    cnt_reg,    cnt_next;

    logic                 issue;
    logic                 lane_end;
    lane_kind_t           kind;
    logic                 push;
    logic                 pop;
    logic [ELEM_BITS-1:0] push_value;

    // Only issue a lane when the queue has room for it and the one in flight.
    assign issue    = job_v_reg
                      && ((3'(cnt_reg) + 3'(s1_v_reg)) <= 3'(OUT_SLOTS - 1));
    assign lane_end = rd_lane_reg == LANE_W'(PACK_LANES - 1);

    always_comb
    begin
        if (rd_lane_reg < job_lane_reg)
            kind = LANE_STORED;
        else if (rd_lane_reg == job_lane_reg)
            kind = LANE_OWN;
        else
            kind = LANE_PAD;
    end

    assign rd_en   = issue && (kind == LANE_STORED);
    assign rd_addr = ADDR_W'(rd_lane_reg * MAX_AREA) + ADDR_W'(job_pos_reg);

    assign stat.job_free = !job_v_reg || (issue && lane_end);
    assign stat.busy     = job_v_reg;
    assign stat.pos      = POS_MAX_W'(job_pos_reg);
    assign stat.rd_lane  = LANE_MAX_W'(rd_lane_reg);

    always_comb
    begin
        job_v_next   = job_v_reg;
        rd_lane_next = rd_lane_reg;
        if (job_load)
        begin
            job_v_next   = 1'b1;
            rd_lane_next = '0;
        end
        else if (issue)
        begin
            if (lane_end)
                job_v_next = 1'b0;
            else
                rd_lane_next = rd_lane_reg + LANE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_value_reg <= job.value[ELEM_BITS-1:0];
            job_lane_reg  <= job.lane[LANE_W-1:0];
            job_pos_reg   <= job.pos[POS_W-1:0];
            job_base_reg  <= job.base;
            job_done_reg  <= job.done;
        end
        if (issue)
        begin
            s1_kind_reg  <= kind;
            s1_value_reg <= job_value_reg;
            s1_dst_reg   <= job_base_reg + DST_W'(rd_lane_reg);
            s1_last_reg  <= lane_end;
            s1_done_reg  <= job_done_reg && lane_end;
        end
    end

    // Queue.
    assign push = s1_v_reg;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        case (s1_kind_reg)
            LANE_STORED: push_value = rd_data;
            LANE_OWN:    push_value = s1_value_reg;
            default:     push_value = '0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == SLOT_W'(OUT_SLOTS - 1)) ? '0
                          : wr_ptr_reg + SLOT_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == SLOT_W'(OUT_SLOTS - 1)) ? '0
                          : rd_ptr_reg + SLOT_W'(1);
        cnt_next = cnt_reg + SLOT_W'(push) - SLOT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_value[wr_ptr_reg] <= push_value;
            q_dst[wr_ptr_reg]   <= s1_dst_reg;
            q_last[wr_ptr_reg]  <= s1_last_reg;
            q_done[wr_ptr_reg]  <= s1_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_v_reg   <= 1'b0;
            rd_lane_reg <= '0;
            s1_v_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            job_v_reg   <= job_v_next;
            rd_lane_reg <= rd_lane_next;
            s1_v_reg    <= issue;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign out_valid   = cnt_reg != '0;
    assign out_value   = VALUE_W'(q_value[rd_ptr_reg]);
    assign dst_index   = q_dst[rd_ptr_reg];
    assign last        = q_last[rd_ptr_reg];
    assign tensor_done = q_done[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    // The queue never holds more entries than it has slots.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOT_W'(OUT_SLOTS))
        else $error("output queue overflow");

    // A new job is only taken once the current one has issued its last lane.
    a_job_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> stat.job_free)
        else $error("job loaded while burst in progress");

    // Issuing the last lane without a new job leaves the unit idle.
    a_job_end: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && lane_end && !job_load) |=> !job_v_reg)
        else $error("job still active after last lane");

    // Every pushed result has a free slot.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (cnt_reg < SLOT_W'(OUT_SLOTS)))
        else $error("push into full output queue");
`endif

endmodule
